FILE: hw/rtl/cbf_pkg.sv
// ----------------------------------------------------------------------------
// cbf_pkg: shared types and constants for the circular byte FIFO
// Command codes, field widths and the step result bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package cbf_pkg;

	// field widths; pointers never exceed 255 since capacity tops out at 256
	localparam int BYTE_W = 8;
	localparam int PTR_W  = 8;
	localparam int CAP_W  = 9;
	localparam int CMD_W  = 3;

	localparam logic [CAP_W-1:0] CAP_MIN = CAP_W'(2);

	typedef enum logic [CMD_W-1:0] {
		CMD_ENQ   = 3'd0,
		CMD_DEQ   = 3'd1,
		CMD_PEEK  = 3'd2,
		CMD_SKIP  = 3'd3,
		CMD_FLUSH = 3'd4
	} cmd_t;

	// outcome of one command against the current pointers
	typedef struct packed {
		logic              ok;
		logic              rd_en;
		logic              wr_en;
		logic [PTR_W-1:0]  head_nx;
		logic [PTR_W-1:0]  tail_nx;
		logic [BYTE_W-1:0] count_nx;
		logic              empty_nx;
		logic              full_nx;
	} step_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cbf_ram.sv
// ----------------------------------------------------------------------------
// cbf_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port; data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/cbf_step.sv
// ----------------------------------------------------------------------------
// cbf_step: command decode and pointer update for the circular byte FIFO
// Works out success, new pointers, fill count and flags for one command.
// ----------------------------------------------------------------------------
`default_nettype none

module cbf_step import cbf_pkg::*; (
	input  wire logic [CMD_W-1:0]  command,
	input  wire logic [BYTE_W-1:0] skip_length,
	input  wire logic [PTR_W-1:0]  head,
	input  wire logic [PTR_W-1:0]  tail,
	input  wire logic [CAP_W-1:0]  cap,
	output step_t                  step
);

	// pointer + 1, wrapping at the capacity
	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p,
			input logic [CAP_W-1:0] c);
		logic [CAP_W-1:0] nxt;
		nxt = {1'b0, p} + CAP_W'(1);
		return (nxt == c) ? '0 : nxt[PTR_W-1:0];
	endfunction

	// bytes held between head and tail
	function automatic logic [BYTE_W-1:0] fill_of(input logic [PTR_W-1:0] h,
			input logic [PTR_W-1:0] t, input logic [CAP_W-1:0] c);
		logic [CAP_W-1:0] wrapped;
		wrapped = c - {1'b0, h} + {1'b0, t};
		return (t >= h) ? BYTE_W'(t - h) : wrapped[BYTE_W-1:0];
	endfunction

	logic              empty;
	logic              full;
	logic [PTR_W-1:0]  head_inc;
	logic [PTR_W-1:0]  tail_inc;
	logic [BYTE_W-1:0] count;
	logic [CAP_W-1:0]  skip_sum;
	logic [PTR_W-1:0]  skip_head;
	logic [PTR_W-1:0]  head_nx;
	logic [PTR_W-1:0]  tail_nx;
	logic              ok;
	logic              rd_en;
	logic              wr_en;

	// current occupancy
	always_comb begin
		head_inc = wrap_inc(head, cap);
		tail_inc = wrap_inc(tail, cap);
		empty    = (head == tail);
		full     = (tail_inc == head);
		count    = fill_of(head, tail, cap);
		skip_sum = {1'b0, head} + {1'b0, skip_length};
		// when the skip is taken, the sum stays below twice the capacity
		skip_head = (skip_sum >= cap) ? PTR_W'(skip_sum - cap) : skip_sum[PTR_W-1:0];
	end

	// command decode
	always_comb begin
		ok      = 1'b0;
		rd_en   = 1'b0;
		wr_en   = 1'b0;
		head_nx = head;
		tail_nx = tail;
		case (cmd_t'(command))
			CMD_ENQ: begin
				ok    = !full;
				wr_en = !full;
				if (!full) begin
					tail_nx = tail_inc;
				end
			end
			CMD_DEQ: begin
				ok    = !empty;
				rd_en = !empty;
				if (!empty) begin
					head_nx = head_inc;
				end
			end
			CMD_PEEK: begin
				ok    = !empty;
				rd_en = !empty;
			end
			CMD_SKIP: begin
				ok = (skip_length <= count);
				if (skip_length <= count) begin
					head_nx = skip_head;
				end
			end
			CMD_FLUSH: begin
				ok = !empty;
				if (!empty) begin
					if (head > tail) begin
						tail_nx = head;
					end else begin
						head_nx = tail;
					end
				end
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	// step bundle: decode outputs, then count and flags after the command
	always_comb begin
		step.ok       = ok;
		step.rd_en    = rd_en;
		step.wr_en    = wr_en;
		step.head_nx  = head_nx;
		step.tail_nx  = tail_nx;
		step.count_nx = fill_of(head_nx, tail_nx, cap);
		step.empty_nx = (head_nx == tail_nx);
		step.full_nx  = (wrap_inc(tail_nx, cap) == head_nx);
	end

endmodule

`default_nettype wire

FILE: hw/rtl/circular_byte_fifo.sv
// ----------------------------------------------------------------------------
// circular_byte_fifo: byte ring buffer with wrap-at-capacity pointers
// Executes enqueue, dequeue, peek, skip and flush commands, one result each.
// ----------------------------------------------------------------------------
// Each result beat follows in the cycle after its command beat is taken.
// Throughput: one command per cycle while results are taken; the result
// and RAM read registers form the single output stage, refilled when taken.
// Reset: head and tail return to 0, capacity to its largest value, no result
// pending. Slot contents are not cleared; a capacity write empties the buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_byte_fifo import cbf_pkg::*; #(
	parameter int DEPTH = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration
	input  wire logic              cfg_we,
	input  wire logic [CAP_W-1:0]  cfg_wdata,
	// command channel
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [CMD_W-1:0]  command,
	input  wire logic [BYTE_W-1:0] write_byte,
	input  wire logic [BYTE_W-1:0] skip_length,
	// result channel
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   accepted,
	output logic [BYTE_W-1:0]      read_byte,
	output logic [BYTE_W-1:0]      fill_count,
	output logic                   is_empty,
	output logic                   is_full
);

	// slots actually addressable: capacity never exceeds 256
	localparam int SLOTS = (DEPTH < 256) ? DEPTH : 256;
	localparam int AW    = $clog2(SLOTS);
	localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(SLOTS);

	logic [CAP_W-1:0]  cap_q;
	logic [PTR_W-1:0]  head_q;
	logic [PTR_W-1:0]  tail_q;
	logic              valid_s1;
	logic              ok_s1;
	logic              rd_s1;
	logic [BYTE_W-1:0] count_s1;
	logic              empty_s1;
	logic              full_s1;
	logic [BYTE_W-1:0] ram_rdata;
	logic [CAP_W-1:0]  cap_clamped;
	logic              in_fire;
	step_t             step;

	assign in_ready = !valid_s1 || out_ready;
	assign in_fire  = in_valid && in_ready;

	// clamp the written capacity into the usable range
	always_comb begin
		if (cfg_wdata < CAP_MIN) begin
			cap_clamped = CAP_MIN;
		end else if (cfg_wdata > CAP_MAX) begin
			cap_clamped = CAP_MAX;
		end else begin
			cap_clamped = cfg_wdata;
		end
	end

	cbf_step u_step (
		.command     (command),
		.skip_length (skip_length),
		.head        (head_q),
		.tail        (tail_q),
		.cap         (cap_q),
		.step        (step)
	);

	cbf_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (in_fire && step.wr_en),
		.waddr (tail_q[AW-1:0]),
		.wdata (write_byte),
		.re    (in_fire && step.rd_en),
		.raddr (head_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// capacity and pointers; a capacity write empties the buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_MAX;
			head_q <= '0;
			tail_q <= '0;
		end else if (cfg_we) begin
			cap_q  <= cap_clamped;
			head_q <= '0;
			tail_q <= '0;
		end else if (in_fire) begin
			head_q <= step.head_nx;
			tail_q <= step.tail_nx;
		end
	end

	// result stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// result stage payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			ok_s1    <= step.ok;
			rd_s1    <= step.rd_en;
			count_s1 <= step.count_nx;
			empty_s1 <= step.empty_nx;
			full_s1  <= step.full_nx;
		end
	end

	assign out_valid  = valid_s1;
	assign accepted   = ok_s1;
	assign read_byte  = rd_s1 ? ram_rdata : '0;
	assign fill_count = count_s1;
	assign is_empty   = empty_s1;
	assign is_full    = full_s1;

	// pointers always lie below the capacity in use
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, head_q} < cap_q) && ({1'b0, tail_q} < cap_q))
		else $error("head or tail pointer beyond capacity");

	// capacity stays within its clamped range
	a_cap_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cap_q >= CAP_MIN) && (cap_q <= CAP_MAX))
		else $error("capacity register out of range");

	// empty flag agrees with the reported count
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (fill_count == '0)))
		else $error("empty flag disagrees with fill count");

	// with at least two slots the buffer is never both empty and full
	a_not_both: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(is_empty && is_full))
		else $error("empty and full flagged together");

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the circular byte FIFO
// Drives command beats with random gaps and result stalls, keeps a shadow
// ring buffer to predict every result beat and compares them field by field
// across several capacity settings, including out-of-range ones.
// ----------------------------------------------------------------------------

module tb;
	import cbf_pkg::*;

	localparam int CLK_PERIOD       = 20;
	localparam int RESET_CYCLES     = 7;
	localparam int RING_DEPTH       = 256;
	localparam int QUIET_LIMIT      = 2000;
	localparam int TAIL_CYCLES      = 8;
	localparam int N_PHASES         = 8;
	localparam int RANDOM_PER_PHASE = 110;

	// command codes the block does not know
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = CMD_W'(CMD_FLUSH) + 1'b1;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = '1;

	// traffic mix for a burst of random commands
	localparam int MODE_FILL  = 0;
	localparam int MODE_DRAIN = 1;
	localparam int MODE_MIX   = 2;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [BYTE_W-1:0] wbyte;
		logic [BYTE_W-1:0] slen;
	} cmd_beat_t;

	typedef struct packed {
		logic              ok;
		logic [BYTE_W-1:0] rbyte;
		logic [BYTE_W-1:0] count;
		logic              empty;
		logic              full;
	} outcome_t;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              cfg_we      = 1'b0;
	logic [CAP_W-1:0]  cfg_wdata   = '0;
	logic              in_valid    = 1'b0;
	logic              in_ready;
	logic [CMD_W-1:0]  command     = '0;
	logic [BYTE_W-1:0] write_byte  = '0;
	logic [BYTE_W-1:0] skip_length = '0;
	logic              out_valid;
	logic              out_ready   = 1'b0;
	logic              accepted;
	logic [BYTE_W-1:0] read_byte;
	logic [BYTE_W-1:0] fill_count;
	logic              is_empty;
	logic              is_full;

	// pending command beats and the results they must produce
	cmd_beat_t cmd_q[$];
	outcome_t  outcome_q[$];
	cmd_beat_t next_beat;
	outcome_t  want;

	// shadow ring buffer
	logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
	int unsigned       ring_head = 0;
	int unsigned       ring_tail = 0;
	int unsigned       ring_cap  = RING_DEPTH;

	int unsigned src_idle_pct   = 0;
	int unsigned sink_stall_pct = 0;
	bit          src_hold       = 1'b0;
	bit          cmd_taken      = 1'b0;
	int          fail_cnt       = 0;
	int          quiet_cycles   = 0;

	circular_byte_fifo #(
		.DEPTH(RING_DEPTH)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.write_byte (write_byte),
		.skip_length(skip_length),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.accepted   (accepted),
		.read_byte  (read_byte),
		.fill_count (fill_count),
		.is_empty   (is_empty),
		.is_full    (is_full)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// bytes held in the shadow ring
	function automatic int unsigned ring_fill();
		return (ring_tail >= ring_head) ? ring_tail - ring_head
			: ring_cap - ring_head + ring_tail;
	endfunction

	// apply one command to the shadow ring and return the result it gives
	function automatic outcome_t fifo_cmd_outcome(input cmd_beat_t b);
		outcome_t    r;
		logic        was_empty;
		logic        was_full;
		int unsigned held;
		r         = '0;
		was_empty = (ring_head == ring_tail);
		was_full  = (((ring_tail + 1) % ring_cap) == ring_head);
		held      = ring_fill();
		case (b.cmd)
			CMD_ENQ: if (!was_full) begin
				ring_mem[8'(ring_tail)] = b.wbyte;
				ring_tail = (ring_tail + 1) % ring_cap;
				r.ok = 1'b1;
			end
			CMD_DEQ, CMD_PEEK: if (!was_empty) begin
				r.rbyte = ring_mem[8'(ring_head)];
				if (b.cmd == CMD_DEQ)
					ring_head = (ring_head + 1) % ring_cap;
				r.ok = 1'b1;
			end
			CMD_SKIP: if (b.slen <= held) begin
				ring_head = (ring_head + b.slen) % ring_cap;
				r.ok = 1'b1;
			end
			CMD_FLUSH: if (!was_empty) begin
				if (ring_head > ring_tail)
					ring_tail = ring_head;
				else
					ring_head = ring_tail;
				r.ok = 1'b1;
			end
			default: ;
		endcase
		r.count = BYTE_W'(ring_fill());
		r.empty = (ring_head == ring_tail);
		r.full  = (((ring_tail + 1) % ring_cap) == ring_head);
		return r;
	endfunction

	function automatic void check_field(input string name, input int unsigned exp_val,
		input int unsigned got_val);
		if (exp_val != got_val) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val,
				got_val);
			fail_cnt++;
		end
	endfunction

	task automatic push_cmd(input logic [CMD_W-1:0] op, input logic [BYTE_W-1:0] wb,
		input logic [BYTE_W-1:0] sl);
		cmd_q.push_back(cmd_beat_t'{op, wb, sl});
	endtask

	// wait until every queued beat is sent and every result is back
	task automatic wait_quiet();
		while (cmd_q.size() != 0 || in_valid || outcome_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// capacity write; the block empties itself, so does the shadow
	task automatic write_capacity(input logic [CAP_W-1:0] value);
		int unsigned eff;
		wait_quiet();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		eff = 32'(value);
		if (eff < CAP_MIN)
			eff = CAP_MIN;
		if (eff > RING_DEPTH)
			eff = RING_DEPTH;
		ring_cap  = eff;
		ring_head = 0;
		ring_tail = 0;
	endtask

	// command driver: next beat once the current one is taken
	always @(negedge clk) begin
		if (!in_valid || cmd_taken) begin
			if (cmd_q.size() != 0 && !src_hold && $urandom_range(99, 0) >= src_idle_pct) begin
				next_beat = cmd_q.pop_front();
				in_valid    <= 1'b1;
				command     <= next_beat.cmd;
				write_byte  <= next_beat.wbyte;
				skip_length <= next_beat.slen;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= ($urandom_range(99, 0) >= sink_stall_pct);
	end

	// monitor: predict on each command beat, check each result beat
	always @(posedge clk) begin
		cmd_taken = in_valid && in_ready;
		if (cmd_taken)
			outcome_q.push_back(fifo_cmd_outcome(cmd_beat_t'{command, write_byte, skip_length}));
		if (out_valid && out_ready) begin
			if (outcome_q.size() == 0) begin
				$display("%0t: result beat with nothing outstanding, expected none, got %0h",
					$time, {accepted, read_byte, fill_count, is_empty, is_full});
				fail_cnt++;
			end else begin
				want = outcome_q.pop_front();
				check_field("accepted", 32'(want.ok), 32'(accepted));
				check_field("read_byte", 32'(want.rbyte), 32'(read_byte));
				check_field("fill_count", 32'(want.count), 32'(fill_count));
				check_field("is_empty", 32'(want.empty), 32'(is_empty));
				check_field("is_full", 32'(want.full), 32'(is_full));
			end
		end
	end

	// watchdog: too long without any beat on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[circular_byte_fifo] ERROR");
			$finish;
		end
	end

	initial begin
		logic [CAP_W-1:0] phase_caps [N_PHASES];
		cmd_beat_t        b;
		int               mode;
		int               burst;
		int               pick;
		int               enq_share;
		int               made;

		phase_caps = '{CAP_W'(256), CAP_W'(2), CAP_W'(3), '1, CAP_W'(0), CAP_W'(300),
			CAP_W'(17), CAP_W'($urandom_range(256, 2))};

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// capacity below range folds to two: one byte fits
		write_capacity(CAP_W'(1));
		push_cmd(CMD_DEQ, 8'h00, 8'h00);
		push_cmd(CMD_PEEK, 8'h00, 8'h00);
		push_cmd(CMD_SKIP, 8'h00, 8'h00);
		push_cmd(CMD_SKIP, 8'h00, 8'hFF);
		push_cmd(CMD_FLUSH, 8'h00, 8'h00);
		push_cmd(CMD_ENQ, 8'hFF, 8'h00);
		push_cmd(CMD_ENQ, 8'h00, 8'hFF);
		push_cmd(CMD_PEEK, 8'h00, 8'h00);
		push_cmd(CMD_SKIP, 8'h00, 8'h01);
		push_cmd(CMD_ENQ, 8'h00, 8'h00);
		push_cmd(CMD_FLUSH, 8'h00, 8'h00);
		push_cmd(CMD_SPARE_LO, 8'hFF, 8'hFF);
		push_cmd(CMD_SPARE_HI, 8'hFF, 8'hFF);

		// four slots: wrap the tail, flush with head above and below tail
		write_capacity(CAP_W'(4));
		push_cmd(CMD_ENQ, 8'h01, 8'h00);
		push_cmd(CMD_ENQ, 8'h80, 8'h00);
		push_cmd(CMD_ENQ, 8'h7F, 8'h00);
		push_cmd(CMD_ENQ, 8'hAA, 8'h00);
		push_cmd(CMD_DEQ, 8'h00, 8'h00);
		push_cmd(CMD_DEQ, 8'h00, 8'h00);
		push_cmd(CMD_ENQ, 8'h33, 8'h00);
		push_cmd(CMD_ENQ, 8'hCC, 8'h00);
		push_cmd(CMD_FLUSH, 8'h00, 8'h00);
		push_cmd(CMD_ENQ, 8'h11, 8'h00);
		push_cmd(CMD_FLUSH, 8'h00, 8'h00);

		for (int i = 0; i < N_PHASES; i++) begin
			write_capacity(phase_caps[3'(i)]);
			case (i % 4)
				0: begin
					src_idle_pct   = 0;
					sink_stall_pct = 0;
				end
				1: begin
					src_idle_pct   = 47;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct   = 0;
					sink_stall_pct = 47;
				end
				default: begin
					src_idle_pct   = 21;
					sink_stall_pct = 21;
				end
			endcase

			// largest ring: fill to the brim, refuse one more, skip it all
			if (phase_caps[3'(i)] == '1) begin
				push_cmd(CMD_FLUSH, 8'h00, 8'h00);
				repeat (RING_DEPTH - 1) push_cmd(CMD_ENQ, BYTE_W'($urandom), 8'h00);
				push_cmd(CMD_ENQ, 8'h5A, 8'h00);
				push_cmd(CMD_SKIP, 8'h00, 8'hFF);
			end

			// bursts biased towards filling, draining or a mix
			made = 0;
			while (made < RANDOM_PER_PHASE) begin
				mode      = $urandom_range(MODE_MIX, MODE_FILL);
				enq_share = (mode == MODE_FILL) ? 70 : (mode == MODE_DRAIN) ? 12 : 34;
				burst     = $urandom_range(24, 1);
				repeat (burst) begin
					pick    = $urandom_range(99, 0);
					b.wbyte = BYTE_W'($urandom);
					b.slen  = ($urandom_range(9, 0) < 7) ? BYTE_W'($urandom_range(4, 0))
						: BYTE_W'($urandom);
					if (pick < 4)
						b.cmd = CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
					else if (pick < 8)
						b.cmd = CMD_FLUSH;
					else if (pick < 18)
						b.cmd = CMD_SKIP;
					else if (pick < 18 + enq_share)
						b.cmd = CMD_ENQ;
					else if ($urandom_range(2, 0) == 0)
						b.cmd = CMD_PEEK;
					else
						b.cmd = CMD_DEQ;
					cmd_q.push_back(b);
					made++;
				end
			end

			// sender holds off mid-phase until every result is back
			if (i == 2) begin
				while (cmd_q.size() > RANDOM_PER_PHASE / 2)
					@(posedge clk);
				src_hold = 1'b1;
				while (in_valid || outcome_q.size() != 0)
					@(posedge clk);
				repeat (TAIL_CYCLES) @(posedge clk);
				src_hold = 1'b0;
			end
		end

		wait_quiet();
		if (fail_cnt == 0)
			$display("[circular_byte_fifo] OK");
		else
			$display("[circular_byte_fifo] ERROR");
		$finish;
	end

endmodule

FILE: circular_byte_fifo.f
hw/rtl/cbf_pkg.sv
hw/rtl/cbf_ram.sv
hw/rtl/cbf_step.sv
hw/rtl/circular_byte_fifo.sv
tb/sv/tb.sv
